// ----- rtl/thermal_fan_curve_controller_macros.svh -----
`ifndef THERMAL_FAN_CURVE_CONTROLLER_MACROS_SVH
`define THERMAL_FAN_CURVE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define TFCC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);
`define TFCC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFCC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define TFCC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

// ----- rtl/tfcc_pkg.sv -----
`default_nettype none

package tfcc_pkg;

  typedef struct packed {
    logic       sensor_sel;
    logic [7:0] temperature;
    logic       read_ok;
  } in_t;

  typedef struct packed {
    logic       fan_write;
    logic [1:0] fan_mode;
    logic [7:0] fan_speed;
    logic       overheat;
    logic       led_write;
    logic [1:0] led_level;
  } out_t;

  localparam int unsigned NUM_THRESH = 6;
  localparam int unsigned NUM_SPEEDS = 8;

  localparam logic [1:0] CFG_AUTO_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD_PACK = 2'd1;
  localparam logic [1:0] CFG_SPEED_PACK     = 2'd2;

  localparam logic [47:0] RESET_THRESH = 48'h504B_4846_443E;
  localparam logic [63:0] RESET_SPEEDS = 64'hFFA0_7870_6860_544D;

  localparam logic [7:0] FIXED_SPEED = 8'h5f;
  localparam logic [7:0] RESET_SPEED = 8'h33;
  localparam logic [7:0] CLEAR_SPEED = 8'h00;

  localparam logic [1:0] FAN_MODE_NONE   = 2'd0;
  localparam logic [1:0] FAN_MODE_AUTO   = 2'd1;
  localparam logic [1:0] FAN_MODE_MANUAL = 2'd2;

  localparam logic [1:0] LED_KEEPALIVE = 2'd0;
  localparam logic [1:0] LED_NORMAL    = 2'd1;
  localparam logic [1:0] LED_WARM      = 2'd2;
  localparam logic [1:0] LED_HOT       = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/thermal_fan_curve_controller.sv -----
// A result beat is registered into the result buffer from the input beat that causes it.
// Throughput: one input beat per cycle; the whole curve evaluation is one compare
// ladder between the state registers and a two-entry result buffer.
// Input stalls only while both result buffer entries are full.
// Reset (rst_n low, synchronous) restores the default curve, clears the readings
// and empties the result buffer; configuration writes are always ready.
`default_nettype none

`include "thermal_fan_curve_controller_macros.svh"

module thermal_fan_curve_controller #(
  parameter int unsigned KEEPALIVE_PERIOD = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,

  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tfcc_pkg::in_t  in_data,

  output logic                out_valid,
  input  wire logic           out_ready,
  output tfcc_pkg::out_t      out_data,

  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [63:0]    cfg_data
);

  localparam int unsigned KA_W = $clog2(KEEPALIVE_PERIOD + 1);
  localparam logic [KA_W-1:0] KA_RELOAD = KA_W'(KEEPALIVE_PERIOD);
  localparam logic [KA_W-1:0] KA_LAST   = KA_W'(1);

  logic        auto_en_r, auto_en_nxt;
  logic [47:0] thr_pack_r, thr_pack_nxt;
  logic [63:0] spd_pack_r, spd_pack_nxt;

  logic [7:0]      cpu_r, cpu_nxt;
  logic [7:0]      gpu_r, gpu_nxt;
  logic            boost_r, boost_nxt;
  logic [7:0]      cur_speed_r, cur_speed_nxt;
  logic [1:0]      last_led_r, last_led_nxt;
  logic [KA_W-1:0] ka_cnt_r, ka_cnt_nxt;
  logic            fixed_sent_r, fixed_sent_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  tfcc_pkg::out_t out_data_r, out_data_nxt;
  tfcc_pkg::out_t skid_data_r, skid_data_nxt;

  logic           in_fire, out_fire, emit;
  tfcc_pkg::out_t res;
  logic [7:0]     sample, t_max, speed_sel;
  logic [tfcc_pkg::NUM_THRESH-1:0] ge;
  logic [1:0]     led_sel, led_fin;
  logic           fw, lw, ka_hit;

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  always_comb begin
    auto_en_nxt  = auto_en_r;
    thr_pack_nxt = thr_pack_r;
    spd_pack_nxt = spd_pack_r;
    if (cfg_valid) begin
      case (cfg_index)
        tfcc_pkg::CFG_AUTO_ENABLE:    auto_en_nxt  = cfg_data[0];
        tfcc_pkg::CFG_THRESHOLD_PACK: thr_pack_nxt = cfg_data[47:0];
        tfcc_pkg::CFG_SPEED_PACK:     spd_pack_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sample = in_data.read_ok ? in_data.temperature : 8'd0;
    cpu_nxt = cpu_r;
    gpu_nxt = gpu_r;
    if (in_fire && auto_en_r) begin
      if (in_data.sensor_sel) begin
        gpu_nxt = sample;
      end else begin
        cpu_nxt = sample;
      end
    end
    t_max = (gpu_nxt > cpu_nxt) ? gpu_nxt : cpu_nxt;

    for (int i = 0; i < int'(tfcc_pkg::NUM_THRESH); i++) begin
      ge[i] = t_max >= thr_pack_r[8*i +: 8];
    end

    if (ge[5]) begin
      speed_sel = spd_pack_r[8*7 +: 8];
    end else if (ge[4]) begin
      speed_sel = spd_pack_r[8*6 +: 8];
    end else if (ge[3]) begin
      speed_sel = spd_pack_r[8*5 +: 8];
    end else if (ge[2]) begin
      speed_sel = spd_pack_r[8*4 +: 8];
    end else if (ge[1]) begin
      speed_sel = spd_pack_r[8*3 +: 8];
    end else if (ge[0]) begin
      speed_sel = (boost_r || ge[1]) ? spd_pack_r[8*2 +: 8] : spd_pack_r[8*1 +: 8];
    end else begin
      speed_sel = spd_pack_r[7:0];
    end

    if (ge[4]) begin
      led_sel = tfcc_pkg::LED_HOT;
    end else if (ge[2]) begin
      led_sel = tfcc_pkg::LED_WARM;
    end else begin
      led_sel = tfcc_pkg::LED_NORMAL;
    end

    fw      = speed_sel != cur_speed_r;
    ka_hit  = ka_cnt_r <= KA_LAST;
    led_fin = ka_hit ? tfcc_pkg::LED_KEEPALIVE : led_sel;
    lw      = led_fin != last_led_r;

    boost_nxt      = boost_r;
    cur_speed_nxt  = cur_speed_r;
    last_led_nxt   = last_led_r;
    ka_cnt_nxt     = ka_cnt_r;
    fixed_sent_nxt = fixed_sent_r;

    res.fan_write = fw;
    res.fan_mode  = fw ? tfcc_pkg::FAN_MODE_MANUAL : tfcc_pkg::FAN_MODE_NONE;
    res.fan_speed = fw ? speed_sel : 8'd0;
    res.overheat  = fw && ge[5];
    res.led_write = lw;
    res.led_level = lw ? led_fin : tfcc_pkg::LED_KEEPALIVE;
    emit = 1'b0;

    if (in_fire) begin
      if (!auto_en_r) begin
        emit           = !fixed_sent_r;
        fixed_sent_nxt = 1'b1;
        res.fan_write  = 1'b1;
        res.fan_mode   = tfcc_pkg::FAN_MODE_AUTO;
        res.fan_speed  = tfcc_pkg::FIXED_SPEED;
        res.overheat   = 1'b0;
        res.led_write  = 1'b0;
        res.led_level  = tfcc_pkg::LED_KEEPALIVE;
      end else begin
        emit         = fw || lw;
        boost_nxt    = (|ge) && (boost_r || ge[1]);
        last_led_nxt = led_fin;
        if (ka_hit) begin
          ka_cnt_nxt    = KA_RELOAD;
          cur_speed_nxt = tfcc_pkg::CLEAR_SPEED;
        end else begin
          ka_cnt_nxt    = ka_cnt_r - KA_LAST;
          cur_speed_nxt = speed_sel;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_r || out_fire) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_en_r    <= 1'b1;
      thr_pack_r   <= tfcc_pkg::RESET_THRESH;
      spd_pack_r   <= tfcc_pkg::RESET_SPEEDS;
      cpu_r        <= 8'd0;
      gpu_r        <= 8'd0;
      boost_r      <= 1'b0;
      cur_speed_r  <= tfcc_pkg::RESET_SPEED;
      last_led_r   <= tfcc_pkg::LED_KEEPALIVE;
      ka_cnt_r     <= KA_RELOAD;
      fixed_sent_r <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      auto_en_r    <= auto_en_nxt;
      thr_pack_r   <= thr_pack_nxt;
      spd_pack_r   <= spd_pack_nxt;
      cpu_r        <= cpu_nxt;
      gpu_r        <= gpu_nxt;
      boost_r      <= boost_nxt;
      cur_speed_r  <= cur_speed_nxt;
      last_led_r   <= last_led_nxt;
      ka_cnt_r     <= ka_cnt_nxt;
      fixed_sent_r <= fixed_sent_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `TFCC_ASSERT_IMP(a_skid_behind_head, clk, rst_n, skid_valid_r, out_valid_r, "skid entry without head entry")
  `TFCC_ASSERT_IMP(a_ka_cnt_nonzero, clk, rst_n, 1'b1, ka_cnt_r != '0, "keepalive counter reached zero")
  `TFCC_ASSERT_NEXT(a_emit_lands, clk, rst_n, in_fire && emit, out_valid_r, "result beat was dropped")
  `TFCC_ASSERT_NEXT(a_fixed_sticky, clk, rst_n, fixed_sent_r, fixed_sent_r, "fixed mode flag cleared")
  `TFCC_ASSERT_IMP(a_auto_once, clk, rst_n, out_valid_r && out_data_r.fan_write && out_data_r.fan_mode == tfcc_pkg::FAN_MODE_AUTO, fixed_sent_r, "fixed command without flag")

endmodule

`default_nettype wire

// ----- tb/fan_curve_checker.sv -----
`timescale 1ns / 100ps

module fan_curve_checker #(
  parameter int unsigned KEEPALIVE_PERIOD = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  tfcc_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  tfcc_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_data,
  output int             fail_count,
  output int             pending,
  output int             samples_seen,
  output int             commands_seen
);

  logic           auto_en;
  logic [47:0]    thr_pack;
  logic [63:0]    spd_pack;
  logic [7:0]     cpu_last;
  logic [7:0]     gpu_last;
  logic           boost;
  logic [7:0]     sent_speed;
  logic [1:0]     shown_led;
  int unsigned    ka_left;
  logic           fixed_sent;
  tfcc_pkg::out_t command_q[$];
  int             mismatches = 0;

  function automatic logic [7:0] thr_at(input int i);
    return thr_pack[8*i +: 8];
  endfunction

  function automatic logic [7:0] spd_at(input int i);
    return spd_pack[8*i +: 8];
  endfunction

  // Advances the controller state by one sample and returns 1 if a command is due.
  function automatic bit predict_command(input tfcc_pkg::in_t s, output tfcc_pkg::out_t r);
    logic [7:0] hottest;
    logic [7:0] duty;
    logic [1:0] level;
    bit         fan_cmd;
    bit         led_cmd;
    bit         hot;
    r = '0;
    if (!auto_en) begin
      if (fixed_sent) return 1'b0;
      fixed_sent  = 1'b1;
      r.fan_write = 1'b1;
      r.fan_mode  = tfcc_pkg::FAN_MODE_AUTO;
      r.fan_speed = tfcc_pkg::FIXED_SPEED;
      return 1'b1;
    end
    if (s.sensor_sel) gpu_last = s.read_ok ? s.temperature : 8'd0;
    else cpu_last = s.read_ok ? s.temperature : 8'd0;
    hottest = (gpu_last > cpu_last) ? gpu_last : cpu_last;
    if (hottest >= thr_at(1)) boost = 1'b1;
    duty = spd_at(0);
    if (hottest >= thr_at(5)) duty = spd_at(7);
    else if (hottest >= thr_at(4)) duty = spd_at(6);
    else if (hottest >= thr_at(3)) duty = spd_at(5);
    else if (hottest >= thr_at(2)) duty = spd_at(4);
    else if (hottest >= thr_at(1)) duty = spd_at(3);
    else if (hottest >= thr_at(0)) duty = boost ? spd_at(2) : spd_at(1);
    else boost = 1'b0;
    fan_cmd = (duty != sent_speed);
    hot = 1'b0;
    if (fan_cmd) begin
      sent_speed = duty;
      hot = (hottest >= thr_at(5));
    end
    if (hottest >= thr_at(4)) level = tfcc_pkg::LED_HOT;
    else if (hottest >= thr_at(2)) level = tfcc_pkg::LED_WARM;
    else level = tfcc_pkg::LED_NORMAL;
    if (ka_left > 0) ka_left--;
    if (ka_left == 0) begin
      level      = tfcc_pkg::LED_KEEPALIVE;
      ka_left    = KEEPALIVE_PERIOD;
      sent_speed = tfcc_pkg::CLEAR_SPEED;
    end
    led_cmd = (level != shown_led);
    if (led_cmd) shown_led = level;
    if (fan_cmd) begin
      r.fan_write = 1'b1;
      r.fan_mode  = tfcc_pkg::FAN_MODE_MANUAL;
      r.fan_speed = duty;
      r.overheat  = hot;
    end
    if (led_cmd) begin
      r.led_write = 1'b1;
      r.led_level = level;
    end
    return fan_cmd || led_cmd;
  endfunction

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    tfcc_pkg::out_t want;
    if (!rst_n) begin
      auto_en    = 1'b1;
      thr_pack   = tfcc_pkg::RESET_THRESH;
      spd_pack   = tfcc_pkg::RESET_SPEEDS;
      cpu_last   = 8'd0;
      gpu_last   = 8'd0;
      boost      = 1'b0;
      sent_speed = tfcc_pkg::RESET_SPEED;
      shown_led  = tfcc_pkg::LED_KEEPALIVE;
      ka_left    = KEEPALIVE_PERIOD;
      fixed_sent = 1'b0;
      mismatches = 0;
      command_q.delete();
      samples_seen  <= 0;
      commands_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tfcc_pkg::CFG_AUTO_ENABLE:    auto_en  = cfg_data[0];
          tfcc_pkg::CFG_THRESHOLD_PACK: thr_pack = cfg_data[47:0];
          tfcc_pkg::CFG_SPEED_PACK:     spd_pack = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        samples_seen <= samples_seen + 1;
        if (predict_command(in_data, want)) command_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        commands_seen <= commands_seen + 1;
        if (command_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, expected none, got %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = command_q.pop_front();
          check_field("fan_write", want.fan_write, out_data.fan_write);
          check_field("fan_mode", want.fan_mode, out_data.fan_mode);
          check_field("fan_speed", want.fan_speed, out_data.fan_speed);
          check_field("overheat", want.overheat, out_data.overheat);
          check_field("led_write", want.led_write, out_data.led_write);
          check_field("led_level", want.led_level, out_data.led_level);
        end
      end
    end
    pending    <= command_q.size();
    fail_count <= mismatches;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned KEEPALIVE_PERIOD  = 5;
  localparam int unsigned NUM_SETTINGS      = 10;
  localparam int unsigned ITEMS_PER_SETTING = 125;
  localparam int unsigned HOLD_OFF_CYCLES   = 60;
  localparam int unsigned SETTLE_CYCLES     = 4;
  localparam logic        CPU_SENSOR        = 1'b0;
  localparam logic        GPU_SENSOR        = 1'b1;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  tfcc_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  tfcc_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = tfcc_pkg::CFG_AUTO_ENABLE;
  logic [63:0]    cfg_data  = '0;

  int unsigned sender_idle_pct   = 28;
  int unsigned receiver_idle_pct = 67;
  logic        hold_off_req      = 1'b0;
  int unsigned hold_left         = 0;
  bit          hold_done         = 1'b0;
  logic [47:0] cur_thresh        = tfcc_pkg::RESET_THRESH;

  int fail_count;
  int pending;
  int samples_seen;
  int commands_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  thermal_fan_curve_controller #(
    .KEEPALIVE_PERIOD(KEEPALIVE_PERIOD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fan_curve_checker #(
    .KEEPALIVE_PERIOD(KEEPALIVE_PERIOD)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .samples_seen  (samples_seen),
    .commands_seen (commands_seen)
  );

  // A single long hold-off lets the result buffer fill so that the input stalls.
  always @(posedge clk) begin
    if (hold_off_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  function automatic tfcc_pkg::in_t sample(input logic sel, input logic [7:0] temp,
                                           input logic ok);
    tfcc_pkg::in_t s;
    s.sensor_sel  = sel;
    s.temperature = temp;
    s.read_ok     = ok;
    return s;
  endfunction

  function automatic tfcc_pkg::in_t make_sample();
    tfcc_pkg::in_t s;
    int  k;
    int  t;
    s.sensor_sel = 1'($urandom_range(1));
    s.read_ok    = ($urandom_range(9) != 0);
    if ($urandom_range(3) == 0) begin
      t = int'($urandom_range(255));
    end else begin
      k = int'($urandom_range(5));
      t = int'(cur_thresh[8*k +: 8]) + int'($urandom_range(6)) - 3;
    end
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    s.temperature = t[7:0];
    return s;
  endfunction

  function automatic logic [47:0] ladder_thresholds();
    logic [47:0] p;
    int          level;
    level = int'($urandom_range(90, 20));
    for (int i = 0; i < 6; i++) begin
      p[8*i +: 8] = level[7:0];
      level += int'($urandom_range(8));
    end
    return p;
  endfunction

  function automatic logic [63:0] duty_table(input bit with_gaps);
    logic [63:0] d;
    d = {$urandom, $urandom};
    if (with_gaps) begin
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(2) == 0) d[8*i +: 8] = 8'h00;
      end
    end
    return d;
  endfunction

  task automatic send_beat(input tfcc_pkg::in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic disabled_interlude();
    write_reg(tfcc_pkg::CFG_AUTO_ENABLE, 64'd0);
    repeat (12) send_beat(make_sample());
    settle();
    write_reg(tfcc_pkg::CFG_AUTO_ENABLE, 64'd1);
  endtask

  initial begin
    logic [47:0] thr_val;
    logic [63:0] spd_val;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(sample(CPU_SENSOR, 8'd0, 1'b1));
    send_beat(sample(GPU_SENSOR, 8'd255, 1'b1));
    send_beat(sample(GPU_SENSOR, 8'd255, 1'b0));
    send_beat(sample(CPU_SENSOR, 8'd61, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd62, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd68, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd65, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd61, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd65, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd70, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd72, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd75, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd79, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd80, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd255, 1'b1));
    send_beat(sample(GPU_SENSOR, 8'd200, 1'b1));
    send_beat(sample(CPU_SENSOR, 8'd255, 1'b0));
    send_beat(sample(GPU_SENSOR, 8'd0, 1'b1));
    send_beat(sample(GPU_SENSOR, 8'd66, 1'b0));
    send_beat(sample(CPU_SENSOR, 8'd0, 1'b0));
    settle();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s == 4) begin
        sender_idle_pct   <= 67;
        receiver_idle_pct <= 28;
      end
      if (s == 7) begin
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
        hold_off_req      <= 1'b1;
      end
      case (s)
        0: begin thr_val = tfcc_pkg::RESET_THRESH; spd_val = tfcc_pkg::RESET_SPEEDS; end
        1: begin thr_val = '0; spd_val = '1; end
        2: begin thr_val = '1; spd_val = '0; end
        3: begin thr_val = ladder_thresholds(); spd_val = duty_table(0); end
        4: begin thr_val = 48'({$urandom, $urandom}); spd_val = duty_table(0); end
        5: begin thr_val = ladder_thresholds(); spd_val = duty_table(1); end
        6: begin thr_val = tfcc_pkg::RESET_THRESH; spd_val = duty_table(1); end
        7: begin thr_val = 48'({$urandom, $urandom}); spd_val = duty_table(0); end
        8: begin thr_val = ladder_thresholds(); spd_val = duty_table(1); end
        default: begin
          thr_val = tfcc_pkg::RESET_THRESH;
          spd_val = tfcc_pkg::RESET_SPEEDS;
        end
      endcase
      write_reg(tfcc_pkg::CFG_THRESHOLD_PACK, {16'd0, thr_val});
      write_reg(tfcc_pkg::CFG_SPEED_PACK, spd_val);
      cur_thresh = thr_val;
      if (s == 2 || s == 8) disabled_interlude();
      repeat (ITEMS_PER_SETTING) send_beat(make_sample());
      settle();
    end

    $display("Covered %0d sample beats and %0d command beats over %0d curve settings,",
             samples_seen, commands_seen, NUM_SETTINGS);
    $display("including fixed automatic mode, re-enabling and a long result hold-off.");
    if (fail_count == 0) begin
      $display("[thermal_fan_curve_controller] OK");
    end else begin
      $display("[thermal_fan_curve_controller] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[thermal_fan_curve_controller] ERROR");
    $finish;
  end

endmodule
